>>> sv/hm128_pkg.sv
// ----------------------------------------------------------------------------
// hm128_pkg
// Types, constants and helper functions for the Hamming(12,8) stream decoder.
// ----------------------------------------------------------------------------
package hm128_pkg;

    localparam int CODE_BITS = 12;
    localparam int DATA_BITS = 8;
    localparam int SYN_BITS  = 4;
    localparam int PEND_BITS = CODE_BITS - 1;
    localparam int CNT_BITS  = 4;
    localparam int COMB_BITS = PEND_BITS + DATA_BITS;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(PEND_BITS);

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [DATA_BITS-1:0] t_byte;
    typedef logic [SYN_BITS-1:0]  t_syn;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // decoded result carried by the output register
    typedef struct packed {
        logic  unc;
        logic  corr;
        t_byte data;
    } t_result;

    function automatic t_syn hm_syndrome(input t_code code);
        t_syn s;
        s = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            if (code[i]) begin
                s = s ^ SYN_BITS'(i + 1);
            end
        end
        return s;
    endfunction

    // data bits at positions 3,5,6,7,9,10,11,12 (1-based)
    function automatic t_byte hm_extract(input t_code code);
        return {code[11], code[10], code[9], code[8],
                code[6], code[5], code[4], code[2]};
    endfunction

endpackage

>>> sv/hm128_front.sv
// ----------------------------------------------------------------------------
// hm128_front
// Collects raw bytes LSB first and pushes each complete 12-bit codeword.
// ----------------------------------------------------------------------------
module hm128_front
    import hm128_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_byte   i_byte,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_code   o_code
);

    logic [PEND_BITS-1:0] r_pend, n_pend;
    logic [CNT_BITS-1:0]  r_cnt,  n_cnt;

    logic [CNT_BITS-1:0]  cnt_c;
    logic [COMB_BITS-1:0] combined;
    logic [CNT_BITS:0]    total;
    logic                 emit;
    logic                 accept;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cnt_c    = (r_cnt > CNT_MAX) ? CNT_MAX : r_cnt;
        combined = COMB_BITS'(r_pend) | (COMB_BITS'(i_byte) << cnt_c);
        total    = (CNT_BITS + 1)'(cnt_c) + (CNT_BITS + 1)'(DATA_BITS);
        emit     = total >= (CNT_BITS + 1)'(CODE_BITS);
        o_push   = accept && emit;
        o_code   = combined[CODE_BITS-1:0];
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        if (accept) begin
            if (emit) begin
                n_pend = PEND_BITS'(combined[COMB_BITS-1:CODE_BITS]);
                n_cnt  = CNT_BITS'(total - (CNT_BITS + 1)'(CODE_BITS));
            end else begin
                n_pend = combined[PEND_BITS-1:0];
                n_cnt  = CNT_BITS'(total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

>>> sv/hm128_fifo.sv
// ----------------------------------------------------------------------------
// hm128_fifo
// Short codeword queue between the front and back parts.
// ----------------------------------------------------------------------------
module hm128_fifo
    import hm128_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_code   i_code,
    input  logic    i_pop,
    output t_code   o_code,
    output t_q_stat o_stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(DEPTH);

    t_code                r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr, n_wr;
    logic [PTR_BITS-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_code       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_BITS'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> sv/hm128_back.sv
// ----------------------------------------------------------------------------
// hm128_back
// Syndrome check, single-bit correction and registered result output.
// ----------------------------------------------------------------------------
module hm128_back
    import hm128_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_code   i_code,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam t_syn SYN_LAST = SYN_BITS'(CODE_BITS);

    logic    r_valid;
    t_result r_result, n_result;
    t_syn    syn;
    t_code   flip;

    assign o_pop    = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        syn           = hm_syndrome(i_code);
        n_result.corr = (syn != '0) && (syn <= SYN_LAST);
        n_result.unc  = syn > SYN_LAST;
        flip          = n_result.corr ? (t_code'(1) << (syn - t_syn'(1))) : '0;
        n_result.data = hm_extract(i_code ^ flip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

>>> sv/hamming_12_8_stream_decoder.sv
// ----------------------------------------------------------------------------
// hamming_12_8_stream_decoder
// Hamming(12,8) single-error-correcting decoder for a packed byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  tdata          tuser
//  s_axis    in   raw_byte[7:0]  -
//  m_axis    out  data_byte[7:0] corrected[0], uncorrectable[1]
//
//  One byte per cycle is taken unless the queue is full; of every three
//  bytes the second and third each complete one codeword (12 bits from
//  8+4, then 4+8). A completed codeword passes the queue, then the out reg.
//  Synchronous active-low reset clears collected bits and the queue.
//  Input stalls only when the codeword queue is full.
// ----------------------------------------------------------------------------
module hamming_12_8_stream_decoder
    import hm128_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] raw_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] o_m_axis_tuser    // [0] corrected, [1] uncorrectable
);

    t_q_stat q_stat;
    logic    push, pop;
    t_code   push_code, head_code;
    t_result result;

    hm128_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_code   (push_code)
    );

    hm128_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_code  (push_code),
        .i_pop   (pop),
        .o_code  (head_code),
        .o_stat  (q_stat)
    );

    hm128_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (head_code),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = result.data;
    assign o_m_axis_tuser = {result.unc, result.corr};

endmodule

>>> tb/hamming_decode_checker.sv
// ----------------------------------------------------------------------------
// hamming_decode_checker
// Watches both stream channels of the Hamming(12,8) decoder. Every byte taken
// on the input is added to its own copy of the collected bits. Each completed
// codeword is decoded here and queued. Every output transfer is checked field
// by field against the oldest queued codeword.
// ----------------------------------------------------------------------------
module hamming_decode_checker
    import hm128_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] raw_byte
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] data_byte
    input  logic [1:0] i_m_tuser,    // [0] corrected, [1] uncorrectable
    output int         o_fail_count,
    output int         o_outstanding
);

    logic [PEND_BITS-1:0] held_bits;
    logic [CNT_BITS-1:0]  held_cnt;
    t_result              decoded_q[$];
    int                   fails;

    initial begin
        fails     = 0;
        held_bits = '0;
        held_cnt  = '0;
    end

    function automatic t_result decode_codeword(input t_code word);
        t_syn    syn;
        t_result res;
        int      k;
        syn = '0;
        for (int p = 1; p <= CODE_BITS; p++) begin
            if (word[p-1]) begin
                syn = syn ^ SYN_BITS'(p);
            end
        end
        res.corr = (syn >= 1) && (syn <= CODE_BITS);
        res.unc  = (syn > CODE_BITS);
        if (res.corr) begin
            word[syn-1] = ~word[syn-1];
        end
        k = 0;
        res.data = '0;
        for (int p = 1; p <= CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                res.data[k] = word[p-1];
                k++;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        logic [COMB_BITS-1:0] merged;
        int                   total;
        t_result              want;
        if (!i_rst_n) begin
            held_bits = '0;
            held_cnt  = '0;
            decoded_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                merged = COMB_BITS'(held_bits) | (COMB_BITS'(i_s_tdata) << held_cnt);
                total  = int'(held_cnt) + DATA_BITS;
                if (total >= CODE_BITS) begin
                    decoded_q.push_back(decode_codeword(merged[CODE_BITS-1:0]));
                    merged = merged >> CODE_BITS;
                    total  = total - CODE_BITS;
                end
                held_bits = merged[PEND_BITS-1:0];
                held_cnt  = CNT_BITS'(total);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected transfer: data_byte %0h, tuser %0b",
                           i_m_tdata, i_m_tuser);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tdata !== want.data) begin
                        $error("data_byte: expected %0h, got %0h", want.data, i_m_tdata);
                        fails++;
                    end
                    if (i_m_tuser[0] !== want.corr) begin
                        $error("corrected: expected %0b, got %0b", want.corr, i_m_tuser[0]);
                        fails++;
                    end
                    if (i_m_tuser[1] !== want.unc) begin
                        $error("uncorrectable: expected %0b, got %0b",
                               want.unc, i_m_tuser[1]);
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= decoded_q.size();
        o_fail_count  <= fails;
    end

endmodule

>>> tb/hamming_12_8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// hamming_12_8_stream_decoder_tb
// Feeds the decoder a packed bit stream of encoded codewords: clean ones,
// single bit errors at every position, syndromes outside the codeword, double
// errors, junk and odd bit counts that shift the byte alignment. Both sides
// idle at random; one long output hold-off backs up the block. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hamming_12_8_stream_decoder_tb;
    import hm128_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int TOTAL_BYTES  = 700;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 8;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    int fail_count;
    int outstanding;

    bit stream_bits[$];
    int sent_bytes    = 0;
    bit tx_burst      = 1'b0;
    bit rx_random     = 1'b0;
    bit long_hold_req = 1'b0;
    int idle_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    hamming_12_8_stream_decoder DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] raw_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [7:0] data_byte
        .o_m_axis_tuser  (m_tuser)     // [0] corrected, [1] uncorrectable
    );

    hamming_decode_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_code encode_byte(input t_byte d);
        t_code w;
        t_syn  syn;
        int    k;
        w   = '0;
        syn = '0;
        k   = 0;
        for (int p = 1; p <= CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                w[p-1] = d[k];
                k++;
            end
        end
        for (int p = 1; p <= CODE_BITS; p++) begin
            if (w[p-1]) begin
                syn = syn ^ SYN_BITS'(p);
            end
        end
        w[0] = syn[0];
        w[1] = syn[1];
        w[3] = syn[2];
        w[7] = syn[3];
        return w;
    endfunction

    // syndrome 13..15: flip position 12 plus position s^12
    function automatic t_code outside_code(input t_byte d, input int syn);
        t_code w;
        w = encode_byte(d);
        w[11] = ~w[11];
        w[(syn ^ 12) - 1] = ~w[(syn ^ 12) - 1];
        return w;
    endfunction

    task automatic push_bits(input t_code w, input int n);
        for (int i = 0; i < n; i++) begin
            stream_bits.push_back(w[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!tx_burst && $urandom_range(0, 99) >= 55) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent_bytes++;
    endtask

    task automatic flush_bytes();
        logic [7:0] b;
        while (stream_bits.size() >= 8) begin
            for (int i = 0; i < 8; i++) begin
                b[i] = stream_bits.pop_front();
            end
            send_byte(b);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic random_codeword();
        t_code w;
        int    r;
        int    p1;
        int    p2;
        r = $urandom_range(0, 99);
        w = encode_byte(t_byte'($urandom_range(0, 255)));
        if (r < 45) begin
            push_bits(w, CODE_BITS);
        end else if (r < 70) begin
            w[$urandom_range(0, CODE_BITS - 1)] ^= 1'b1;
            push_bits(w, CODE_BITS);
        end else if (r < 80) begin
            push_bits(outside_code(t_byte'($urandom_range(0, 255)),
                                   $urandom_range(13, 15)), CODE_BITS);
        end else if (r < 88) begin
            p1 = $urandom_range(0, CODE_BITS - 1);
            p2 = (p1 + $urandom_range(1, CODE_BITS - 1)) % CODE_BITS;
            w[p1] ^= 1'b1;
            w[p2] ^= 1'b1;
            push_bits(w, CODE_BITS);
        end else if (r < 94) begin
            push_bits(t_code'($urandom_range(0, 4095)), CODE_BITS);
        end else begin
            // odd bit count shifts codeword alignment against byte edges
            push_bits(t_code'($urandom_range(0, 4095)), $urandom_range(1, 7));
        end
    endtask

    // receiver
    initial begin : receiver
        int rx_hold;
        rx_hold = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (!rx_random) begin
                m_tready <= 1'b1;
            end else if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                rx_hold = idle_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("hamming_12_8_stream_decoder_tb NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        int burst_end;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        burst_end  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: clean extremes, every single-bit error, syndromes 13..15,
        // all-ones codeword
        push_bits(encode_byte(8'h00), CODE_BITS);
        push_bits(encode_byte(8'hFF), CODE_BITS);
        for (int p = 0; p < CODE_BITS; p++) begin
            push_bits(encode_byte(t_byte'($urandom_range(0, 255))) ^ (t_code'(1) << p),
                      CODE_BITS);
        end
        for (int s = 13; s <= 15; s++) begin
            push_bits(outside_code(t_byte'($urandom_range(0, 255)), s), CODE_BITS);
        end
        push_bits(12'hFFF, CODE_BITS);
        flush_bytes();
        wait_drained();

        rx_random = 1'b1;
        while (sent_bytes < TOTAL_BYTES) begin
            if (!hold_done && sent_bytes >= 250) begin
                long_hold_req = 1'b1;
                tx_burst      = 1'b1;
                burst_end     = sent_bytes + 40;
                hold_done     = 1'b1;
            end
            if (!pause_done && sent_bytes >= 450) begin
                tx_burst = 1'b0;
                wait_drained();
                pause_done = 1'b1;
            end
            if (sent_bytes >= 600 && sent_bytes < 660) begin
                tx_burst  = 1'b1;
                rx_random = 1'b0;
            end else begin
                tx_burst  = hold_done && (sent_bytes < burst_end);
                rx_random = 1'b1;
            end
            random_codeword();
            flush_bytes();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("hamming_12_8_stream_decoder_tb OK");
        end else begin
            $display("hamming_12_8_stream_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/hm128_pkg.sv
sv/hm128_front.sv
sv/hm128_fifo.sv
sv/hm128_back.sv
sv/hamming_12_8_stream_decoder.sv
tb/hamming_decode_checker.sv
tb/hamming_12_8_stream_decoder_tb.sv
